@@ sv/nvt_pkg.sv @@
// Shared types and codes for the named variable table.
package nvt_pkg;

    // Longest name that can be stored, in bytes.
    localparam int NAME_MAX_BYTES = 15;
    localparam int NAME_LOW_W     = 64;
    localparam int NAME_HIGH_W    = 56;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 3;

    // Stored form of a name: bytes after the terminator are zero.
    typedef struct packed {
        logic [NAME_HIGH_W-1:0] high;
        logic [NAME_LOW_W-1:0]  low;
    } key_t;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_UPDATED   = 3'd0;
    localparam status_t STATUS_CREATED   = 3'd1;
    localparam status_t STATUS_FULL      = 3'd2;
    localparam status_t STATUS_FOUND     = 3'd3;
    localparam status_t STATUS_NOT_FOUND = 3'd4;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

endpackage

@@ sv/named_variable_table_core.sv @@
// Top level of the named variable table: request FSM, linear search and result register.
//
// s_* carries one request per handshake: s_tuser holds the command (0 set,
// 1 get), s_tdata holds name_low, name_high and new_value. The name is cut at
// the first space or NUL and at NAME_BYTES-1 bytes before use. m_* returns one
// result per request, status and read_value in m_tdata. Set answers updated,
// created or table full; get answers found (with the value) or not found
// (value 0). Entries are never removed.
//
// Keys and values sit in two RAMs with registered read data. A request
// scans the stored entries in insertion order, one read per cycle, and stops
// at the first match. m_tvalid and s_tready rise together when the result
// is loaded; a miss reads every stored entry. The single RAM read port sets
// the scan rate.
//
// Reset empties the table (entry count to zero) and drops any pending result;
// RAM contents are not cleared and need not be. A stalled result waits in the
// output register while the next request is accepted and searched; that
// request then holds in its final state until the register frees.
module named_variable_table_core #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // name_low[63:0], name_high[119:64], new_value[151:120]
    input  logic [0:0]   s_tuser,   // command[0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // status[2:0], read_value[34:3], zero fill[39:35]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    localparam int LOW_LSB   = 0;
    localparam int HIGH_LSB  = nvt_pkg::NAME_LOW_W;
    localparam int VALUE_LSB = nvt_pkg::NAME_LOW_W + nvt_pkg::NAME_HIGH_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    nvt_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg;        // number of valid entries
    logic [CW-1:0] rd_idx_reg;       // next entry to read
    logic          cmp_valid_reg;    // RAM data of cmp_idx_reg is on the read port
    logic [AW-1:0] cmp_idx_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [nvt_pkg::VALUE_W-1:0] hit_value_reg;

    // captured request
    logic                        cmd_reg;
    nvt_pkg::key_t               key_reg;
    logic [nvt_pkg::VALUE_W-1:0] value_reg;

    // result register
    logic                        m_valid_reg;
    nvt_pkg::status_t            status_reg;
    logic [nvt_pkg::VALUE_W-1:0] read_value_reg;

    // ---------------------------------------------------------------
    // Name canonicalization on the incoming request
    // ---------------------------------------------------------------
    nvt_pkg::key_t in_key;

    nvt_canon #(
        .NAME_BYTES (NAME_BYTES)
    ) u_canon (
        .name_low  (s_tdata[LOW_LSB +: nvt_pkg::NAME_LOW_W]),
        .name_high (s_tdata[HIGH_LSB +: nvt_pkg::NAME_HIGH_W]),
        .key       (in_key)
    );

    // ---------------------------------------------------------------
    // Key and value storage
    // ---------------------------------------------------------------
    logic                        key_we;
    logic                        value_we;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    nvt_pkg::key_t               key_rd;
    logic [nvt_pkg::VALUE_W-1:0] value_rd;

    nvt_ram #(
        .WIDTH ($bits(nvt_pkg::key_t)),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    nvt_ram #(
        .WIDTH (nvt_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (value_we),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_addr (rd_addr),
        .rd_data (value_rd)
    );

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic in_fire;
    logic issue_en;
    logic match;
    logic scan_done;
    logic out_free;
    logic finish;
    logic full;

    assign s_tready  = (state_reg == nvt_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // one read per cycle until a hit or the end of the valid entries
    assign issue_en  = (state_reg == nvt_pkg::ST_SEARCH) && (rd_idx_reg < count_reg);
    assign rd_addr   = rd_idx_reg[AW-1:0];
    assign match     = cmp_valid_reg && (key_rd == key_reg);
    assign scan_done = !issue_en && !cmp_valid_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign finish    = (state_reg == nvt_pkg::ST_DONE) && out_free;
    assign full      = (count_reg == CAP_COUNT);

    // table update happens once, when the result is loaded
    always_comb begin
        key_we   = 1'b0;
        value_we = 1'b0;
        wr_addr  = hit_idx_reg;
        if (finish && (cmd_reg == nvt_pkg::CMD_SET)) begin
            if (hit_reg) begin
                value_we = 1'b1;
            end else if (!full) begin
                key_we   = 1'b1;
                value_we = 1'b1;
                wr_addr  = count_reg[AW-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nvt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = nvt_pkg::ST_SEARCH;
                end
            end
            nvt_pkg::ST_SEARCH: begin
                if (match || scan_done) begin
                    state_next = nvt_pkg::ST_DONE;
                end
            end
            nvt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = nvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nvt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nvt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (in_fire) begin
                cmp_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
            end else if (state_reg == nvt_pkg::ST_SEARCH) begin
                cmp_valid_reg <= issue_en && !match;
                if (match) begin
                    hit_reg <= 1'b1;
                end
            end else begin
                cmp_valid_reg <= 1'b0;
            end

            if (key_we) begin
                count_reg <= count_reg + CW'(1);
            end

            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg    <= s_tuser[0];
            key_reg    <= in_key;
            value_reg  <= s_tdata[VALUE_LSB +: nvt_pkg::VALUE_W];
            rd_idx_reg <= '0;
        end else if (issue_en) begin
            rd_idx_reg <= rd_idx_reg + CW'(1);
        end

        cmp_idx_reg <= rd_idx_reg[AW-1:0];

        if (match && (state_reg == nvt_pkg::ST_SEARCH)) begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_value_reg <= value_rd;
        end

        if (finish) begin
            read_value_reg <= '0;
            if (cmd_reg == nvt_pkg::CMD_SET) begin
                if (hit_reg) begin
                    status_reg <= nvt_pkg::STATUS_UPDATED;
                end else if (!full) begin
                    status_reg <= nvt_pkg::STATUS_CREATED;
                end else begin
                    status_reg <= nvt_pkg::STATUS_FULL;
                end
            end else begin
                if (hit_reg) begin
                    status_reg     <= nvt_pkg::STATUS_FOUND;
                    read_value_reg <= hit_value_reg;
                end else begin
                    status_reg <= nvt_pkg::STATUS_NOT_FOUND;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, read_value_reg, status_reg};

endmodule

@@ sv/nvt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module nvt_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/nvt_canon.sv @@
// Name canonicalizer: cuts a name at the first space or NUL and at the length limit.
module nvt_canon #(
    parameter int NAME_BYTES = 16
) (
    input  logic [nvt_pkg::NAME_LOW_W-1:0]  name_low,
    input  logic [nvt_pkg::NAME_HIGH_W-1:0] name_high,
    output nvt_pkg::key_t                   key
);

    localparam int NB = nvt_pkg::NAME_MAX_BYTES;

    logic [NB*8-1:0] raw;
    logic [NB*8-1:0] cut;
    logic [NB-1:0]   keep;

    assign raw = {name_high, name_low};

    // keep[i] is high while every byte up to i is a live name character and i is under NAME_BYTES-1
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            keep[i] = (i < NAME_BYTES - 1)
                   && (raw[i*8 +: 8] != nvt_pkg::CHAR_NUL)
                   && (raw[i*8 +: 8] != nvt_pkg::CHAR_SPACE);
            if (i > 0) begin
                keep[i] = keep[i] && keep[i-1];
            end
            cut[i*8 +: 8] = keep[i] ? raw[i*8 +: 8] : 8'h00;
        end
    end

    assign key.low  = cut[nvt_pkg::NAME_LOW_W-1:0];
    assign key.high = cut[NB*8-1:nvt_pkg::NAME_LOW_W];

endmodule

@@ tb/named_variable_table_checker.sv @@
`timescale 1ns / 100ps
// Answer checker for the named variable table: tracks the table and compares every answer.
module named_variable_table_checker #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,   // name_low[63:0], name_high[119:64], new_value[151:120]
    input  logic [0:0]   s_tuser,   // command[0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,   // status[2:0], read_value[34:3], zero fill[39:35]
    output int           error_count,
    output int           outstanding_answers
);

    typedef struct packed {
        nvt_pkg::status_t            status;
        logic [nvt_pkg::VALUE_W-1:0] value;
    } answer_t;

    nvt_pkg::key_t               known_keys   [CAPACITY];
    logic [nvt_pkg::VALUE_W-1:0] known_values [CAPACITY];
    int                          entry_total = 0;
    int                          failures    = 0;
    answer_t                     expected_answers[$];

    // Name as the table stores it: cut at the first space or NUL, bytes after it zero.
    function automatic nvt_pkg::key_t canonical_key(logic [119:0] raw);
        logic [119:0] k;
        bit           cut;
        k   = '0;
        cut = 1'b0;
        for (int i = 0; i < nvt_pkg::NAME_MAX_BYTES && i < NAME_BYTES - 1; i++) begin
            if (raw[8*i +: 8] == nvt_pkg::CHAR_NUL || raw[8*i +: 8] == nvt_pkg::CHAR_SPACE) begin
                cut = 1'b1;
            end
            if (!cut) begin
                k[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return nvt_pkg::key_t'(k);
    endfunction

    // Applies one request to the tracked table and returns the answer it must produce.
    function automatic answer_t apply_request(logic command, nvt_pkg::key_t key,
                                              logic [nvt_pkg::VALUE_W-1:0] value);
        answer_t a;
        int      hit;
        a.status = nvt_pkg::STATUS_NOT_FOUND;
        a.value  = '0;
        hit      = entry_total;
        for (int i = 0; i < entry_total; i++) begin
            if (hit == entry_total && known_keys[i] == key) begin
                hit = i;
            end
        end
        if (command == nvt_pkg::CMD_SET) begin
            if (hit < entry_total) begin
                known_values[hit] = value;
                a.status          = nvt_pkg::STATUS_UPDATED;
            end else if (entry_total < CAPACITY) begin
                known_keys[entry_total]   = key;
                known_values[entry_total] = value;
                entry_total++;
                a.status = nvt_pkg::STATUS_CREATED;
            end else begin
                a.status = nvt_pkg::STATUS_FULL;
            end
        end else if (hit < entry_total) begin
            a.status = nvt_pkg::STATUS_FOUND;
            a.value  = known_values[hit];
        end
        return a;
    endfunction

    always @(posedge aclk) begin : scoreboard
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            entry_total = 0;
            expected_answers.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(apply_request(s_tuser[0],
                    canonical_key(s_tdata[119:0]), s_tdata[151:120]));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.value  = m_tdata[34:3];
                if (expected_answers.size() == 0) begin
                    if (failures < 10) begin
                        $display("unexpected answer: status %0d value %h",
                                 got.status, got.value);
                    end
                    failures++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status != want.status || got.value != want.value) begin
                        if (failures < 10) begin
                            $display(
                                "mismatch: expected status %0d value %h, got %0d value %h",
                                want.status, want.value, got.status, got.value);
                        end
                        failures++;
                    end
                end
            end
        end
        error_count         <= failures;
        outstanding_answers <= expected_answers.size();
    end

endmodule

@@ tb/named_variable_table_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the named variable table: clock, reset, request stimulus and verdict.
module named_variable_table_core_tb;

    localparam int POOL_SIZE        = 80;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int QUIET_LIMIT      = 3000;   // cycles without any handshake
    localparam int TAIL_CYCLES      = 100;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [151:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tready = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [39:0]  m_tdata;

    int error_count;
    int outstanding_answers;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    logic [119:0] pool_names   [POOL_SIZE];
    int           pool_lengths [POOL_SIZE];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    named_variable_table_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    named_variable_table_checker answer_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .error_count         (error_count),
        .outstanding_answers (outstanding_answers)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog: no handshake on either channel for too long means a hang.
    always @(posedge aclk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [119:0] text_name(string s);
        logic [119:0] n;
        n = '0;
        for (int i = 0; i < s.len() && i < nvt_pkg::NAME_MAX_BYTES; i++) begin
            n[8*i +: 8] = s[i];
        end
        return n;
    endfunction

    // Any byte that does not end a name.
    function automatic logic [7:0] name_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == nvt_pkg::CHAR_SPACE);
        return b;
    endfunction

    // Wire form of a stored name: random terminator, sometimes junk behind it.
    function automatic logic [119:0] encode_name(logic [119:0] stored, int len);
        logic [119:0] raw;
        raw = stored;
        if (len < nvt_pkg::NAME_MAX_BYTES) begin
            raw[8*len +: 8] = $urandom_range(0, 1) ? nvt_pkg::CHAR_SPACE : nvt_pkg::CHAR_NUL;
            if ($urandom_range(0, 1)) begin
                for (int i = len + 1; i < nvt_pkg::NAME_MAX_BYTES; i++) begin
                    raw[8*i +: 8] = 8'($urandom_range(0, 255));
                end
            end
        end
        return raw;
    endfunction

    // Presents one request and holds it until the block takes it.
    task automatic send_request(input logic command, input logic [119:0] name,
                                input logic [31:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= {value, name};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic wait_answers_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding_answers != 0);
    endtask

    initial begin
        logic [127:0] noise;
        logic [119:0] name;
        logic         command;
        int           active_names;
        int           pick;

        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_names[k]   = '0;
            pool_lengths[k] = (k == 0) ? 0 : $urandom_range(1, nvt_pkg::NAME_MAX_BYTES);
            for (int i = 0; i < pool_lengths[k]; i++) begin
                pool_names[k][8*i +: 8] = name_char();
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty name, terminators, junk after the cut, full-length names,
        // extreme values, update versus create, get with a value that is ignored.
        send_request(nvt_pkg::CMD_GET, '0, 32'h1234_5678);
        send_request(nvt_pkg::CMD_SET, '0, 32'h8000_0000);
        send_request(nvt_pkg::CMD_GET, text_name(" junk"), '0);
        send_request(nvt_pkg::CMD_SET, text_name("alpha"), 32'h7fff_ffff);
        send_request(nvt_pkg::CMD_GET, text_name("alpha") | (120'h7a7a << 48), '0);
        send_request(nvt_pkg::CMD_GET, text_name("alpha beta"), '1);
        send_request(nvt_pkg::CMD_SET, text_name("alpha zz"), '0);
        send_request(nvt_pkg::CMD_GET, text_name("alph"), '0);
        send_request(nvt_pkg::CMD_GET, text_name("alphab"), '0);
        send_request(nvt_pkg::CMD_SET, '1, 32'hffff_ffff);
        send_request(nvt_pkg::CMD_GET, '1, '0);
        send_request(nvt_pkg::CMD_SET, {8'hfe, {112{1'b1}}}, 32'h0000_0001);
        send_request(nvt_pkg::CMD_GET, {8'hfe, {112{1'b1}}}, '0);
        send_request(nvt_pkg::CMD_GET, {56'h0, {64{1'b1}}}, '0);
        send_request(nvt_pkg::CMD_SET,
                     {48'habcd_ef01_2345, nvt_pkg::CHAR_SPACE, {64{1'b1}}}, 32'h5555_aaaa);
        send_request(nvt_pkg::CMD_GET, {56'h0, {64{1'b1}}}, '0);
        send_request(nvt_pkg::CMD_SET, text_name("a b"), 32'hdead_beef);
        send_request(nvt_pkg::CMD_GET, text_name("a"), '0);
        send_request(nvt_pkg::CMD_SET, text_name("abcdefghijklmno"), 32'h0000_0000);
        send_request(nvt_pkg::CMD_GET, text_name("abcdefghijklmno"), '0);
        send_request(nvt_pkg::CMD_SET, text_name(""), 32'h7fff_ffff);
        send_request(nvt_pkg::CMD_GET, '0, '0);

        // Random phases; the name pool widens so the table fills and then overflows.
        for (int phase = 0; phase < 4; phase++) begin
            wait_answers_drained();
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;  active_names = 10;
                end
                1: begin
                    sender_idle_pct = 74; receiver_stall_pct = 0;  active_names = 30;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 74; active_names = 60;
                end
                default: begin
                    sender_idle_pct = 24; receiver_stall_pct = 24; active_names = POOL_SIZE;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    noise   = {$urandom, $urandom, $urandom, $urandom};
                    name    = noise[119:0];
                    command = ($urandom_range(0, 3) != 0) ? nvt_pkg::CMD_GET : nvt_pkg::CMD_SET;
                end else begin
                    pick    = $urandom_range(0, active_names - 1);
                    name    = encode_name(pool_names[pick], pool_lengths[pick]);
                    command = $urandom_range(0, 1) ? nvt_pkg::CMD_GET : nvt_pkg::CMD_SET;
                end
                send_request(command, name, $urandom);
            end
        end

        wait_answers_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
